// ----- rtl/srdf_pkg.sv -----
// Shared constants and helpers for the signed radix digit formatter.
// Holds widths, ASCII codes and the digit-to-character mapping.
// No dependencies.
package srdf_pkg;

  // Magnitude width and the sizes that follow from it.
  localparam int MAG_WIDTH   = 32;
  localparam int BIT_CNT_W   = $clog2(MAG_WIDTH);
  localparam int DIGIT_CNT_W = $clog2(MAG_WIDTH + 1);

  // Radix register.
  localparam int          RADIX_W     = 6;
  localparam logic [5:0]  RADIX_MIN   = 6'd2;
  localparam logic [5:0]  RADIX_MAX   = 6'd36;
  localparam logic [5:0]  RADIX_RESET = 6'd10;

  // ASCII codes.
  localparam int          CHAR_W     = 7;
  localparam logic [6:0]  CHAR_PLUS  = 7'h2B;
  localparam logic [6:0]  CHAR_MINUS = 7'h2D;
  localparam logic [6:0]  CHAR_ZERO  = 7'h30;
  localparam logic [6:0]  CHAR_A     = 7'h41;
  localparam logic [5:0]  DEC_DIGITS = 6'd10;

  // Clamp a raw radix value into the supported range of 2 to 36.
  function automatic logic [5:0] clamp_radix(input logic [5:0] r);
    logic [5:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit value to its ASCII character: 0-9 then A-Z.
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] res;
    if (d < DEC_DIGITS) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_A + {1'b0, d - DEC_DIGITS};
    end
    return res;
  endfunction

endpackage

// ----- rtl/signed_radix_digit_formatter_top.sv -----
// Signed radix digit formatter, top level.
// Converts a signed integer to ASCII text with a bit-serial divider.
// Depends on srdf_pkg.
// Usage:
//   Configuration: radix_wdata is written into the radix register on a clock
//   edge where radix_we is high. Values below 2 act as base 2, values above
//   36 act as base 36. Write it only while busy is low.
//   Input: an item (value) is taken on a clock edge where start is high and
//   busy is low. busy stays high until the last character is on the outputs.
//   Output: each character appears on text_char for one cycle with strobe
//   high; last marks the final character of the number. The receiver cannot
//   stall, so every character is sent the cycle it is produced.
// Sequence:
//   The sign character comes out the cycle after start is taken. Each digit
//   is then computed in the one-bit-per-cycle restoring divider, and the D
//   digits (1 to 32) are sent back-to-back from a digit stack once the
//   quotient reaches zero.
// Reset:
//   rst (synchronous, active high) returns the block to idle, clears the
//   strobe and sets the radix to 10.
module signed_radix_digit_formatter_top
  import srdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  radix_we,
  input  logic [RADIX_W-1:0]    radix_wdata,
  input  logic                  start,
  input  logic signed [31:0]    value,
  output logic                  busy,
  output logic                  strobe,
  output logic [CHAR_W-1:0]     text_char,
  output logic                  last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     base;
  logic [MAG_WIDTH-1:0]   mag;
  logic [RADIX_W-1:0]     rem;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIGIT_CNT_W-1:0] digit_cnt;
  logic [RADIX_W-1:0]     stack [MAG_WIDTH];

  logic                   accept;
  logic [MAG_WIDTH-1:0]   mag_in;
  logic [RADIX_W:0]       rem_sh;
  logic [RADIX_W:0]       rem_diff;
  logic                   q_bit;
  logic [RADIX_W-1:0]     rem_next;
  logic [MAG_WIDTH-1:0]   mag_next;
  logic                   digit_done;
  logic                   push;
  logic                   pop;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // Magnitude as an unsigned value so the most negative input is exact.
  assign mag_in = value[31] ? MAG_WIDTH'(-{1'b0, value}) : MAG_WIDTH'(value);

  // One restoring-division step: bring in the next dividend bit.
  assign rem_sh   = {rem, mag[MAG_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, base};
  assign q_bit    = (rem_sh >= {1'b0, base});
  assign rem_next = q_bit ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
  assign mag_next = {mag[MAG_WIDTH-2:0], q_bit};

  assign digit_done = (state == ST_DIV) && (bit_cnt == BIT_CNT_W'(MAG_WIDTH - 1));
  assign push       = digit_done;
  assign pop        = (state == ST_EMIT);

  // Radix configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  // Control sequencer, divider registers and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      digit_cnt <= '0;
      bit_cnt   <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // Sign character goes out while the first digit is computed.
            strobe    <= 1'b1;
            text_char <= value[31] ? CHAR_MINUS : CHAR_PLUS;
            last      <= 1'b0;
            base      <= clamp_radix(radix);
            mag       <= mag_in;
            rem       <= '0;
            bit_cnt   <= '0;
            digit_cnt <= '0;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          mag     <= mag_next;
          bit_cnt <= bit_cnt + 1'b1;
          if (digit_done) begin
            // Remainder is the next digit; the quotient becomes the dividend.
            rem       <= '0;
            digit_cnt <= digit_cnt + 1'b1;
            if (mag_next == '0) begin
              state <= ST_EMIT;
            end
          end else begin
            rem <= rem_next;
          end
        end
        ST_EMIT: begin
          strobe    <= 1'b1;
          text_char <= digit_char(stack[0]);
          last      <= (digit_cnt == DIGIT_CNT_W'(1));
          digit_cnt <= digit_cnt - 1'b1;
          if (digit_cnt == DIGIT_CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit stack: digits arrive least significant first and leave from the top.
  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= rem_next;
      for (int i = 1; i < MAG_WIDTH; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < MAG_WIDTH - 1; i++) begin
        stack[i] <= stack[i+1];
      end
      stack[MAG_WIDTH-1] <= '0;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the signed radix digit formatter: signed values in, ASCII text out.
// It predicts every character and compares it; it depends on srdf_pkg and the top module.
module tb_top;
  import srdf_pkg::*;

  // One expected character of the text.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } text_char_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                radix_we;
  logic [RADIX_W-1:0]  radix_wdata;
  logic                start;
  logic signed [31:0]  value;
  logic                busy;
  logic                strobe;
  logic [CHAR_W-1:0]   text_char;
  logic                last;

  logic [RADIX_W-1:0]  radix_cfg;
  text_char_t          pending_chars[$];
  int                  error_count = 0;

  signed_radix_digit_formatter_top uut (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .start       (start),
    .value       (value),
    .busy        (busy),
    .strobe      (strobe),
    .text_char   (text_char),
    .last        (last)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue the text that one value should produce under the current radix.
  function automatic void predict_text(input logic [31:0] v);
    logic [RADIX_W-1:0] base;
    logic [31:0]        mag;
    logic [5:0]         dig;
    logic [CHAR_W-1:0]  digits[$];
    text_char_t         t;
    base = (radix_cfg < RADIX_MIN) ? RADIX_MIN :
           (radix_cfg > RADIX_MAX) ? RADIX_MAX : radix_cfg;
    // The magnitude is unsigned, so the most negative value is exact.
    mag = v[31] ? (32'd0 - v) : v;
    do begin
      dig = 6'(mag % {26'd0, base});
      if (dig < DEC_DIGITS) begin
        digits.push_front(CHAR_ZERO + {1'b0, dig});
      end else begin
        digits.push_front(CHAR_A + {1'b0, dig - DEC_DIGITS});
      end
      mag = mag / {26'd0, base};
    end while (mag != 32'd0);
    t.ch  = v[31] ? CHAR_MINUS : CHAR_PLUS;
    t.fin = 1'b0;
    pending_chars.push_back(t);
    foreach (digits[i]) begin
      t.ch  = digits[i];
      t.fin = (i == digits.size() - 1);
      pending_chars.push_back(t);
    end
  endfunction

  // Compare every strobed character with the oldest expectation.
  always @(posedge clk) begin
    text_char_t t;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got char %h last %b",
                 $time, text_char, last);
        error_count++;
      end else begin
        t = pending_chars.pop_front();
        if (text_char !== t.ch) begin
          $display("%0t: text_char mismatch, expected %h, got %h", $time, t.ch, text_char);
          error_count++;
        end
        if (last !== t.fin) begin
          $display("%0t: last mismatch, expected %b, got %b", $time, t.fin, last);
          error_count++;
        end
      end
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_value(input logic [31:0] v);
    @(negedge clk);
    start = 1'b1;
    value = v;
    do @(posedge clk); while (busy);
    predict_text(v);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every expected character has come and the block is idle.
  task automatic drain_items();
    while (pending_chars.size() != 0 || busy) @(posedge clk);
  endtask

  // Write the radix register while the block is idle.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain_items();
    @(negedge clk);
    radix_we    = 1'b1;
    radix_wdata = r;
    @(negedge clk);
    radix_we  = 1'b0;
    radix_cfg = r;
  endtask

  // Random values of several shapes: full range, small, shifted and boundaries.
  function automatic logic [31:0] rand_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 4))
      1: r = $urandom_range(0, 99);
      2: r = r >> $urandom_range(0, 31);
      3: begin
        case ($urandom_range(0, 4))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = 32'h8000_0001;
          3: r = 32'h0000_0000;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1 && r != 32'h8000_0000) begin
      r = 32'd0 - r;
    end
    return r;
  endfunction

  // Default radix of ten after reset: zero, extremes and long decimal numbers.
  task automatic test_reset_radix();
    logic [31:0] vals[] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'd1234567890, 32'd0 - 32'd987654321};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Radix bounds, including the saturation below two and above thirty-six.
  task automatic test_radix_bounds();
    write_radix(6'd2);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
    write_radix(6'd36);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'h8000_0000);
    send_value(32'd0);
    write_radix(6'd0);
    send_value(32'd5);
    write_radix(6'd1);
    send_value(32'd0 - 32'd6);
    write_radix(6'd37);
    send_value(32'd71);
    write_radix(6'd63);
    send_value(32'd0 - 32'd1295);
    write_radix(6'd16);
    send_value(32'hDEAD_BEEF);
    send_value(32'hFEDC_BA98);
  endtask

  // Random values in bursts with random gaps, over several radix settings.
  task automatic test_random_items();
    int sent;
    int burst;
    for (int phase = 0; phase < 8; phase++) begin
      // Each radix change waits for the block to drain completely.
      case (phase)
        0: write_radix(6'd2);
        1: write_radix(6'd36);
        default: write_radix(6'($urandom_range(0, 63)));
      endcase
      sent = 0;
      while (sent < 32) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < 32; b++) begin
          send_value(rand_value());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 400)) @(negedge clk);
        end
      end
    end
  endtask

  // Reset, run each test in turn, then report.
  initial begin
    rst         = 1'b1;
    radix_we    = 1'b0;
    radix_wdata = '0;
    start       = 1'b0;
    value       = '0;
    radix_cfg   = RADIX_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_radix();
    test_radix_bounds();
    test_random_items();

    drain_items();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
